### rtl/core/ckt_pkg.sv
// Shared types and codes for the compacting key table.
// Depends on nothing; imported by ckt_entry_ram and compacting_key_table.
`default_nettype none

package ckt_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 8;

   // Field widths fixed by the item formats
   localparam int KEY_W = 32;
   localparam int PAY_W = 32;
   localparam int POS_W = 8;

   // Operation codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;
   localparam logic [1:0] MODE_LIST   = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [POS_W-1:0]        position;
      logic signed [KEY_W-1:0] found_key;
      logic [PAY_W-1:0]        found_payload;
      logic                    last;
   } rsp_type;

   // One stored table entry
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } entry_type;

endpackage : ckt_pkg

`default_nettype wire

### rtl/core/compacting_key_table.sv
// Compacting key table: an ordered table of key/payload entries held in one
// synchronous RAM with registered read data. Insert appends an entry at the
// end. Search walks the table from position 0 and reports the first match,
// or not-found when the key is absent. Remove does the same search, then
// moves every later entry down one slot. List forms one item per cycle; each
// item reaches the ports the cycle after it is formed. The single RAM read
// port walks the table one entry per cycle. busy is high while a search,
// remove or list walks the table; an insert never raises it; results appear
// on rsp_item for exactly one cycle under rsp_valid, and the receiver must
// take them then, as the block cannot be stalled.
`default_nettype none

module compacting_key_table
   import ckt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_item,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_LIST
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    count_ff;
   logic [IW-1:0]    ptr_ff;
   logic [1:0]       mode_ff;
   logic [KEY_W-1:0] key_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   entry_type        wr_data;
   logic [IW-1:0]    rd_addr;
   entry_type        rd_data;

   logic             accept;
   logic             full;
   logic             at_end;
   logic [IW-1:0]    ptr_next;

   ckt_entry_ram #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept   = start && (state_ff == S_IDLE);
   assign full     = (count_ff == CW'(CAPACITY));
   assign ptr_next = ptr_ff + IW'(1);
   // Entry at ptr is the last one in the table
   assign at_end   = ((CW'(ptr_ff) + CW'(1)) == count_ff);

   // Read entry 0 while idle, otherwise fetch one ahead of the pointer
   assign rd_addr = (state_ff == S_IDLE) ? '0 : ptr_next;

   // Append on insert, move entries down one slot while shifting
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = IW'(count_ff);
      wr_data.key     = req_item.key;
      wr_data.payload = req_item.payload;
      if (state_ff == S_SHIFT) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff - IW'(1);
         wr_data = rd_data;
      end else if (accept && (req_item.mode == MODE_INSERT) && !full) begin
         wr_en = 1'b1;
      end
   end

   // Sequencer: state, count, pointer and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff <= req_item.mode;
                  key_ff  <= req_item.key;
                  ptr_ff  <= '0;
                  rsp_ff  <= '0;
                  rsp_ff.last <= 1'b1;
                  case (req_item.mode)
                     MODE_INSERT: begin
                        rsp_valid_ff <= 1'b1;
                        if (full) begin
                           rsp_ff.status <= STATUS_FULL;
                        end else begin
                           rsp_ff.status        <= STATUS_OK;
                           rsp_ff.position      <= POS_W'(count_ff);
                           rsp_ff.found_key     <= req_item.key;
                           rsp_ff.found_payload <= req_item.payload;
                           count_ff             <= count_ff + CW'(1);
                        end
                     end
                     MODE_REMOVE, MODE_SEARCH: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_ff.status <= STATUS_NOT_FOUND;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_ff.status <= STATUS_EMPTY;
                        end else begin
                           state_ff <= S_LIST;
                        end
                     end
                  endcase
               end
            end

            S_SCAN: begin
               if (rd_data.key == key_ff) begin
                  // First match: report it, then compact on remove
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.status        <= STATUS_OK;
                  rsp_ff.position      <= POS_W'(ptr_ff);
                  rsp_ff.found_key     <= rd_data.key;
                  rsp_ff.found_payload <= rd_data.payload;
                  rsp_ff.last          <= 1'b1;
                  if (mode_ff == MODE_REMOVE) begin
                     if (at_end) begin
                        count_ff <= count_ff - CW'(1);
                        state_ff <= S_IDLE;
                     end else begin
                        ptr_ff   <= ptr_next;
                        state_ff <= S_SHIFT;
                     end
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else if (at_end) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ff        <= '0;
                  rsp_ff.status <= STATUS_NOT_FOUND;
                  rsp_ff.last   <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_next;
               end
            end

            S_SHIFT: begin
               // Entry at ptr is written one slot down this cycle
               if (at_end) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_next;
               end
            end

            S_LIST: begin
               rsp_valid_ff         <= 1'b1;
               rsp_ff.status        <= STATUS_OK;
               rsp_ff.position      <= POS_W'(ptr_ff);
               rsp_ff.found_key     <= rd_data.key;
               rsp_ff.found_payload <= rd_data.payload;
               rsp_ff.last          <= at_end;
               if (at_end) begin
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_next;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule : compacting_key_table

`default_nettype wire

### rtl/core/ckt_entry_ram.sv
// Entry storage: one write port, one read port with registered read data.
// Depends on ckt_pkg for the entry type.
`default_nettype none

module ckt_entry_ram
   import ckt_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : ckt_entry_ram

`default_nettype wire
